FILE: hw/rtl/sprp_pkg.sv
// sprp_pkg: shared constants, register index codes and the job record
// passed from the match front end to the emit back end.
// No dependencies.
package sprp_pkg;

   localparam int MAX_PATTERN_BYTES     = 8;
   localparam int MAX_REPLACEMENT_BYTES = 8;
   localparam int JOB_BYTES             = (MAX_PATTERN_BYTES > MAX_REPLACEMENT_BYTES) ?
                                          MAX_PATTERN_BYTES : MAX_REPLACEMENT_BYTES;
   localparam int LEN_W                 = 4;
   localparam int LANE_W                = $clog2(JOB_BYTES);
   localparam int WIN_IDX_W             = $clog2(MAX_PATTERN_BYTES);
   localparam int QUEUE_DEPTH           = 4;
   localparam int QPTR_W                = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W                = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CSR_SEARCH_PATTERN     = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_TEXT   = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   // one input beat's worth of output: num bytes from data, or a bare end marker
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] data;
      logic [LEN_W-1:0]          num;
      logic                      stream_end;
   } job_type;

endpackage

FILE: hw/rtl/stream_pattern_replace.sv
// stream_pattern_replace: streaming find-and-replace, pattern and replacement up to 8 bytes.
// Results of an accepted byte are written into the job queue and offered once they reach its head.
// Throughput: one result beat per cycle while rsp_stall is low; one byte per cycle while each byte
// yields at most one result. A byte that yields several results holds the emit side until all are taken; a 4-entry job
// queue lets the match side keep accepting meanwhile.
// Reset clears configuration to zero, empties the window and the job queue.
module stream_pattern_replace (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_present,
   output logic        rsp_last_of_run,
   output logic        rsp_stream_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import sprp_pkg::*;

   job_type push_job, head;
   logic    push, pop, q_full, q_empty;

   sprp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_full           (q_full),
      .push             (push),
      .job              (push_job)
   );

   sprp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   sprp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (q_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_stream_done  (rsp_stream_done)
   );

`ifndef SYNTHESIS
   a_bare_marker_ends_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_present |-> rsp_last_of_run && rsp_stream_done && rsp_out_byte == 8'h00)
      else $error("bare end marker without run and stream end");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_last_of_run)
      else $error("stream end on a beat that is not last of its run");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("job pushed into a full queue");
`endif

endmodule

FILE: hw/rtl/sprp_front.sv
// sprp_front: configuration registers, match window and per-beat classification.
// Produces one job record per input beat that yields output.
// Depends on sprp_pkg.
module sprp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_end_of_input,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [63:0]           csr_data,
   input  logic                  q_full,
   output logic                  push,
   output sprp_pkg::job_type     job
);
   import sprp_pkg::*;

   logic [63:0]                         pat_ff, repl_ff;
   logic [LEN_W-1:0]                    plen_ff, rlen_ff;
   logic [WIN_IDX_W-1:0]                cnt_ff, cnt_in;
   logic [MAX_PATTERN_BYTES-1:0][7:0]   win_ff, win_in;

   logic                                accept;
   logic [WIN_IDX_W-1:0]                eff_cnt;
   logic [LEN_W-1:0]                    cnt_app;
   logic [MAX_PATTERN_BYTES-1:0][7:0]   win_app, win_sh;
   logic                                full, hit;
   logic [LEN_W-1:0]                    sat_len;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   assign sat_len = (csr_data[LEN_W-1:0] > LEN_W'(MAX_PATTERN_BYTES)) ?
                    LEN_W'(MAX_PATTERN_BYTES) : csr_data[LEN_W-1:0];

   always_comb begin
      eff_cnt = ({1'b0, cnt_ff} >= plen_ff) ? '0 : cnt_ff;
      cnt_app = LEN_W'({1'b0, eff_cnt}) + LEN_W'(1);
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         win_app[i] = (WIN_IDX_W'(i) == eff_cnt) ? req_in_byte : win_ff[i];
      end
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         win_sh[i] = (i < MAX_PATTERN_BYTES - 1) ? win_app[(i + 1) % MAX_PATTERN_BYTES]
                                                 : win_app[i];
      end
      full = (cnt_app == plen_ff);
      hit  = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         if ((LEN_W'(i) < plen_ff) && (win_app[i] != pat_ff[8*i +: 8])) hit = 1'b0;
      end
   end

   // window update and job build
   always_comb begin
      win_in         = win_ff;
      cnt_in         = cnt_ff;
      job.data       = '0;
      job.num        = '0;
      job.stream_end = req_end_of_input;
      if (plen_ff == '0) begin
         job.data[0] = req_in_byte;
         job.num     = LEN_W'(1);
      end else if (full && hit) begin
         job.data = repl_ff;
         job.num  = rlen_ff;
         win_in   = win_app;
         cnt_in   = '0;
      end else if (full) begin
         job.data = win_app;
         // on end of stream the whole window drains behind the oldest byte
         job.num  = req_end_of_input ? plen_ff : LEN_W'(1);
         win_in   = win_sh;
         cnt_in   = WIN_IDX_W'(plen_ff - LEN_W'(1));
      end else begin
         job.data = win_app;
         job.num  = req_end_of_input ? cnt_app : '0;
         win_in   = win_app;
         cnt_in   = WIN_IDX_W'(cnt_app);
      end
      if (req_end_of_input) cnt_in = '0;
   end

   assign push = accept & ((job.num != '0) | req_end_of_input);

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         repl_ff <= '0;
         plen_ff <= '0;
         rlen_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (accept && plen_ff != '0) cnt_ff <= cnt_in;
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_SEARCH_PATTERN:     pat_ff  <= csr_data;
               CSR_PATTERN_LENGTH: begin
                  plen_ff <= sat_len;
                  cnt_ff  <= '0;
               end
               CSR_REPLACEMENT_TEXT:   repl_ff <= csr_data;
               CSR_REPLACEMENT_LENGTH: rlen_ff <= (csr_data[LEN_W-1:0] >
                                                   LEN_W'(MAX_REPLACEMENT_BYTES)) ?
                                                  LEN_W'(MAX_REPLACEMENT_BYTES) :
                                                  csr_data[LEN_W-1:0];
               default:                pat_ff  <= pat_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && plen_ff != '0) win_ff <= win_in;
   end

endmodule

FILE: hw/rtl/sprp_queue.sv
// sprp_queue: small register queue of job records between front and back end.
// Depends on sprp_pkg.
module sprp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sprp_pkg::job_type  push_job,
   input  logic               pop,
   output sprp_pkg::job_type  head,
   output logic               full,
   output logic               empty
);
   import sprp_pkg::*;

   job_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QCNT_W-1:0]   cnt_ff;

   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + QPTR_W'(1);
         if (pop)  rd_ff <= rd_ff + QPTR_W'(1);
         if (push && !pop)      cnt_ff <= cnt_ff + QCNT_W'(1);
         else if (!push && pop) cnt_ff <= cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_job;
   end

endmodule

FILE: hw/rtl/sprp_back.sv
// sprp_back: walks the head job one output beat per cycle while rsp_stall is low and marks run/stream ends.
// Depends on sprp_pkg.
module sprp_back (
   input  logic               clock,
   input  logic               reset,
   input  sprp_pkg::job_type  head,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_byte_present,
   output logic               rsp_last_of_run,
   output logic               rsp_stream_done
);
   import sprp_pkg::*;

   logic [LANE_W-1:0] idx_ff, idx_in;
   logic              beat;

   assign rsp_valid        = ~empty;
   assign rsp_byte_present = (head.num != '0);
   assign rsp_out_byte     = rsp_byte_present ? head.data[idx_ff] : 8'h00;
   assign rsp_last_of_run  = ~rsp_byte_present |
                             (LEN_W'({1'b0, idx_ff}) + LEN_W'(1) == head.num);
   assign rsp_stream_done  = rsp_last_of_run & head.stream_end;

   assign beat   = rsp_valid & ~rsp_stall;
   assign pop    = beat & rsp_last_of_run;
   assign idx_in = rsp_last_of_run ? '0 : idx_ff + LANE_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (beat) begin
         idx_ff <= idx_in;
      end
   end

endmodule
